// ===== rtl/core/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the best split search
// Log table, log2 helper, register indexes and the cell control group.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int LG_W    = 22;
	localparam int QB_MAX  = 36;
	localparam int QB_W    = 6;
	localparam int SCORE_W = 20;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [15:0]        LN2_Q16   = 16'd45426;
	localparam logic [16:0]        ONE_Q16   = 17'h10000;

	localparam logic [QB_W-1:0] QB_GINI  = 6'd17;
	localparam logic [QB_W-1:0] QB_SPLIT = 6'd20;
	localparam logic [QB_W-1:0] QB_ENT   = 6'd36;

	localparam logic [1:0] REG_CRITERION = 2'd0;
	localparam logic [1:0] REG_CLASSES   = 2'd1;
	localparam logic [1:0] REG_TOTAL     = 2'd2;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_SAMPLE   = 1'b1;
	localparam logic CRIT_GINI    = 1'b0;
	localparam logic CRIT_ENTROPY = 1'b1;

	// log2(1 + i/16) in Q16
	localparam logic [16:0] LG_TAB [17] = '{
		17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
		17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52910,
		17'd56228, 17'd59434, 17'd62534, 17'd65536
	};

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       inc;
		logic [3:0] label;
		logic       s1;
		logic       s2;
		logic       s3;
		logic       shift;
		logic       crit;
	} bss_cell_ctl_t;

	// log2 in Q16: leading one, table step and linear interpolation
	function automatic logic [LG_W-1:0] lg_q16(input logic [31:0] x);
		logic [4:0]  e;
		logic [31:0] m;
		logic [3:0]  idx;
		logic [15:0] frac;
		logic [16:0] lo;
		logic [16:0] hi;
		logic [32:0] prod;
		e = '0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) begin
				e = 5'(b);
			end
		end
		m    = x << (5'd31 - e);
		idx  = m[30:27];
		frac = m[26:11];
		lo   = LG_TAB[5'(idx)];
		hi   = LG_TAB[5'(idx) + 5'd1];
		prod = 33'(hi - lo) * 33'(frac);
		if (x == 32'd0) begin
			lg_q16 = '0;
		end else begin
			lg_q16 = LG_W'({e, 16'b0}) + LG_W'(lo) + LG_W'(prod[32:16]);
		end
	endfunction

endpackage

// ===== rtl/core/bss_in_if.sv =====
// ----------------------------------------------------------------------------
// bss_in_if: input channel of the best split search
// Carries class total loads and sorted samples.
// ----------------------------------------------------------------------------
interface bss_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  class_label;
	logic [15:0] class_total;
	logic [31:0] sample_value;
	logic        last;

	modport source(output valid, cmd, class_label, class_total, sample_value, last,
		input ready);
	modport sink(input valid, cmd, class_label, class_total, sample_value, last,
		output ready);
endinterface

// ===== rtl/core/bss_out_if.sv =====
// ----------------------------------------------------------------------------
// bss_out_if: result channel of the best split search
// Carries the best split of one run.
// ----------------------------------------------------------------------------
interface bss_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] best_value;
	logic [19:0] best_impurity;
	logic [15:0] left_count;

	modport source(output valid, found, best_value, best_impurity, left_count,
		input ready);
	modport sink(input valid, found, best_value, best_impurity, left_count,
		output ready);
endinterface

// ===== rtl/core/bss_cell.sv =====
// ----------------------------------------------------------------------------
// bss_cell: one class slot of the counting chain
// Holds a class count and total, forms its impurity terms and shifts them on.
// ----------------------------------------------------------------------------
module bss_cell import bss_pkg::*; #(
	parameter int IDX         = 0,
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 16,
	localparam int OP_W   = (COUNT_BITS > LG_W) ? COUNT_BITS : LG_W,
	localparam int TERM_W = COUNT_BITS + OP_W,
	localparam int NC_W   = $clog2(MAX_CLASSES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bss_cell_ctl_t       ctl,
	input  logic [15:0]         total,
	input  logic [NC_W-1:0]     nc,
	input  logic [TERM_W-1:0]   tl_in,
	input  logic [TERM_W-1:0]   tr_in,
	output logic [TERM_W-1:0]   tl_out,
	output logic [TERM_W-1:0]   tr_out
);

	logic                  hit;
	logic                  in_use;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] rest;
	logic [COUNT_BITS-1:0] l_s1;
	logic [COUNT_BITS-1:0] r_s1;
	logic [COUNT_BITS-1:0] l_s2;
	logic [COUNT_BITS-1:0] r_s2;
	logic [OP_W-1:0]       opl_s2;
	logic [OP_W-1:0]       opr_s2;
	logic [TERM_W-1:0]     tl_q;
	logic [TERM_W-1:0]     tr_q;

	assign hit    = ({28'b0, ctl.label} == 32'(IDX));
	assign in_use = (32'(IDX) < 32'(nc));
	assign rest   = (total_q >= count_q) ? total_q - count_q : '0;

	// count samples of this class, clear at run end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.inc && hit) begin
			count_q <= count_q + 1'b1;
		end
	end

	// hold the class total
	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			total_q <= COUNT_BITS'(total);
		end
	end

	// snapshot, log step for entropy (the count itself for Gini), product; then shift toward the chain head
	always_ff @(posedge clk) begin
		if (ctl.s1) begin
			l_s1 <= in_use ? count_q : '0;
			r_s1 <= in_use ? rest : '0;
		end
		if (ctl.s2) begin
			l_s2   <= l_s1;
			r_s2   <= r_s1;
			opl_s2 <= (ctl.crit == CRIT_ENTROPY) ? OP_W'(lg_q16(32'(l_s1))) : OP_W'(l_s1);
			opr_s2 <= (ctl.crit == CRIT_ENTROPY) ? OP_W'(lg_q16(32'(r_s1))) : OP_W'(r_s1);
		end
		if (ctl.s3) begin
			tl_q <= TERM_W'(l_s2) * TERM_W'(opl_s2);
			tr_q <= TERM_W'(r_s2) * TERM_W'(opr_s2);
		end else if (ctl.shift) begin
			tl_q <= tl_in;
			tr_q <= tr_in;
		end
	end

	assign tl_out = tl_q;
	assign tr_out = tr_q;

endmodule

// ===== rtl/core/bss_div.sv =====
// ----------------------------------------------------------------------------
// bss_div: shared restoring divider
// One quotient bit a cycle, quotient limited to qb bits with a saturation flag.
// ----------------------------------------------------------------------------
module bss_div import bss_pkg::*; #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [QB_W-1:0]   qb,
	output logic              busy,
	output logic              done,
	output logic              sat,
	output logic [QB_MAX-1:0] q
);

	localparam int W = (NUM_W > DEN_W + QB_MAX) ? NUM_W : DEN_W + QB_MAX;

	logic              busy_q;
	logic              done_q;
	logic              sat_q;
	logic              sat_c;
	logic              ge;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      dv_q;
	logic [QB_W-1:0]   cnt_q;
	logic [QB_MAX-1:0] q_q;

	assign sat_c = ((W'(num) >> qb) >= W'(den));
	assign ge    = (rem_q >= dv_q);

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= !sat_c;
			done_q <= sat_c;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// subtract and shift one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= sat_c;
			q_q   <= '0;
			rem_q <= W'(num);
			dv_q  <= W'(den) << (qb - 1'b1);
			cnt_q <= qb - 1'b1;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			q_q   <= {q_q[QB_MAX-2:0], ge};
			dv_q  <= dv_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign sat  = sat_q;
	assign q    = q_q;

endmodule

// ===== rtl/core/best_split_sorted_stream_unit.sv =====
// A load item is taken in ST_IDLE; a sample that is not a boundary passes
// ST_CHK and ST_UPD. A scored boundary also drains the terms along the cell chain
// and waits on the shared one-bit-a-cycle divider, for both sides and the split
// with Gini and once with entropy. One item is worked on at a time.
// Reset clears counts and run state, presets config; class totals hold no reset.
// ----------------------------------------------------------------------------
// best_split_sorted_stream_unit: best split threshold over one sorted feature
// Counts classes in a chain of cells and scores boundaries by Gini or entropy.
// ----------------------------------------------------------------------------
module best_split_sorted_stream_unit import bss_pkg::*; #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bss_in_if.sink      samples,
	bss_out_if.source   result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);

	localparam int OP_W   = (COUNT_BITS > LG_W) ? COUNT_BITS : LG_W;
	localparam int TERM_W = COUNT_BITS + OP_W;
	localparam int SW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int SIDE_W = SW + LG_W;
	localparam int ACC_W  = ((TERM_W > SIDE_W) ? TERM_W : SIDE_W) + $clog2(MAX_CLASSES) + 2;
	localparam int NUM_W  = ACC_W + 17;
	localparam int DEN_W  = 2 * SW;
	localparam int NC_W   = $clog2(MAX_CLASSES + 1);
	localparam int CNT_W  = $clog2(MAX_CLASSES);
	localparam int PG_W   = 17 + SW;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_CHK  = 5'd1;
	localparam logic [4:0] ST_S2   = 5'd2;
	localparam logic [4:0] ST_S3   = 5'd3;
	localparam logic [4:0] ST_SH   = 5'd4;
	localparam logic [4:0] ST_ED   = 5'd5;
	localparam logic [4:0] ST_EM   = 5'd6;
	localparam logic [4:0] ST_DEG  = 5'd7;
	localparam logic [4:0] ST_DEW  = 5'd8;
	localparam logic [4:0] ST_DLG  = 5'd9;
	localparam logic [4:0] ST_DLW  = 5'd10;
	localparam logic [4:0] ST_DRG  = 5'd11;
	localparam logic [4:0] ST_DRW  = 5'd12;
	localparam logic [4:0] ST_CM   = 5'd13;
	localparam logic [4:0] ST_DNG  = 5'd14;
	localparam logic [4:0] ST_DNW  = 5'd15;
	localparam logic [4:0] ST_BEST = 5'd16;
	localparam logic [4:0] ST_UPD  = 5'd17;

	// configuration
	logic        crit_q;
	logic [4:0]  classes_q;
	logic [15:0] total_items_q;
	logic [NC_W-1:0] nc;
	logic [15:0] n_eff;

	// run state
	logic [4:0]            state_q;
	logic [3:0]            label_q;
	logic [31:0]           value_q;
	logic                  last_q;
	logic [COUNT_BITS-1:0] left_q;
	logic [31:0]           prev_q;
	logic                  have_q;
	logic [SCORE_W-1:0]    best_score_q;
	logic [31:0]           best_key_q;
	logic [COUNT_BITS-1:0] best_left_q;
	logic                  seen_q;

	// scoring datapath
	logic [SW-1:0]      l_s1;
	logic [SW-1:0]      r_s1;
	logic [LG_W-1:0]    lgl_s2;
	logic [LG_W-1:0]    lgr_s2;
	logic [SIDE_W-1:0]  posl_s3;
	logic [SIDE_W-1:0]  posr_s3;
	logic [DEN_W-1:0]   ll_s3;
	logic [DEN_W-1:0]   rr_s3;
	logic [ACC_W-1:0]   sl_q;
	logic [ACC_W-1:0]   sr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   d_q;
	logic [NUM_W-1:0]   x_q;
	logic [3:0]         k_q;
	logic [16:0]        gl_q;
	logic [16:0]        gr_q;
	logic [PG_W-1:0]    pl_q;
	logic [PG_W-1:0]    pr_q;
	logic [SCORE_W-1:0] score_q;
	logic [ACC_W-1:0]   pos_c;
	logic [ACC_W-1:0]   neg_c;
	logic [16:0]        gsel_c;
	logic [31:0]        r_wide;

	// output register
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [31:0]           out_value_q;
	logic [SCORE_W-1:0]    out_imp_q;
	logic [COUNT_BITS-1:0] out_left_q;

	// divider
	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [QB_W-1:0]   div_qb;
	logic              div_busy;
	logic              div_done;
	logic              div_sat;
	logic [QB_MAX-1:0] div_q;

	// chain
	bss_cell_ctl_t     ctl;
	logic [TERM_W-1:0] tl_w [MAX_CLASSES+1];
	logic [TERM_W-1:0] tr_w [MAX_CLASSES+1];

	logic in_acc;
	logic boundary;
	logic upd_go;

	assign nc = (32'(classes_q) > 32'(MAX_CLASSES)) ? NC_W'(MAX_CLASSES) : NC_W'(classes_q);
	assign n_eff = (total_items_q == 16'd0) ? 16'd1 : total_items_q;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc   = samples.valid && samples.ready;
	assign boundary = have_q && (value_q != prev_q);
	assign upd_go   = (state_q == ST_UPD) && !(last_q && out_valid_q && !result.ready);

	assign r_wide = (32'(total_items_q) > 32'(left_q)) ?
		32'(total_items_q) - 32'(left_q) : 32'd0;
	assign pos_c  = ACC_W'(posl_s3) + ACC_W'(posr_s3);
	assign neg_c  = sl_q + sr_q;
	assign gsel_c = (div_sat || div_q > QB_MAX'(ONE_Q16)) ?
		17'd0 : ONE_Q16 - div_q[16:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q        <= CRIT_GINI;
			classes_q     <= 5'd2;
			total_items_q <= 16'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CRITERION: crit_q        <= wr_data[0];
				REG_CLASSES:   classes_q     <= wr_data[4:0];
				REG_TOTAL:     total_items_q <= wr_data;
				default: ;
			endcase
		end
	end

	// cell control
	always_comb begin
		ctl.clear = upd_go && last_q;
		ctl.load  = in_acc && (samples.cmd == CMD_LOAD);
		ctl.inc   = upd_go;
		ctl.label = (state_q == ST_IDLE) ? samples.class_label : label_q;
		ctl.s1    = (state_q == ST_CHK) && boundary;
		ctl.s2    = (state_q == ST_S2);
		ctl.s3    = (state_q == ST_S3);
		ctl.shift = (state_q == ST_SH);
		ctl.crit  = crit_q;
	end

	assign tl_w[MAX_CLASSES] = '0;
	assign tr_w[MAX_CLASSES] = '0;

	for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
		bss_cell #(
			.IDX(i),
			.MAX_CLASSES(MAX_CLASSES),
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.total(samples.class_total),
			.nc(nc),
			.tl_in(tl_w[i+1]),
			.tr_in(tr_w[i+1]),
			.tl_out(tl_w[i]),
			.tr_out(tr_w[i])
		);
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_qb    = QB_GINI;
		unique case (state_q)
			ST_DLG: begin
				div_start = (l_s1 != '0);
				div_num   = NUM_W'(sl_q) << 16;
				div_den   = ll_s3;
			end
			ST_DRG: begin
				div_start = (r_s1 != '0);
				div_num   = NUM_W'(sr_q) << 16;
				div_den   = rr_s3;
			end
			ST_DNG: begin
				div_start = 1'b1;
				div_num   = NUM_W'(pl_q) + NUM_W'(pr_q);
				div_den   = DEN_W'(n_eff);
				div_qb    = QB_SPLIT;
			end
			ST_DEG: begin
				div_start = 1'b1;
				div_num   = x_q;
				div_den   = DEN_W'(n_eff);
				div_qb    = QB_ENT;
			end
			default: ;
		endcase
	end

	bss_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.qb(div_qb),
		.busy(div_busy),
		.done(div_done),
		.sat(div_sat),
		.q(div_q)
	);

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			left_q       <= '0;
			prev_q       <= '0;
			have_q       <= 1'b0;
			best_score_q <= SCORE_MAX;
			best_key_q   <= '0;
			best_left_q  <= '0;
			seen_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && samples.cmd == CMD_SAMPLE) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK:  state_q <= boundary ? ST_S2 : ST_UPD;
				ST_S2:   state_q <= ST_S3;
				ST_S3:   state_q <= ST_SH;
				ST_SH: begin
					if (cnt_q == CNT_W'(MAX_CLASSES - 1)) begin
						state_q <= (crit_q == CRIT_ENTROPY) ? ST_ED : ST_DLG;
					end
				end
				ST_ED:   state_q <= ST_EM;
				ST_EM: begin
					if (k_q == 4'd15) begin
						state_q <= ST_DEG;
					end
				end
				ST_DEG:  state_q <= ST_DEW;
				ST_DEW: begin
					if (div_done) begin
						state_q <= ST_BEST;
					end
				end
				ST_DLG:  state_q <= (l_s1 != '0) ? ST_DLW : ST_DRG;
				ST_DLW: begin
					if (div_done) begin
						state_q <= ST_DRG;
					end
				end
				ST_DRG:  state_q <= (r_s1 != '0) ? ST_DRW : ST_CM;
				ST_DRW: begin
					if (div_done) begin
						state_q <= ST_CM;
					end
				end
				ST_CM:   state_q <= ST_DNG;
				ST_DNG:  state_q <= ST_DNW;
				ST_DNW: begin
					if (div_done) begin
						state_q <= ST_BEST;
					end
				end
				ST_BEST: begin
					if (!seen_q || score_q < best_score_q) begin
						best_score_q <= score_q;
						best_key_q   <= prev_q;
						best_left_q  <= left_q;
					end
					seen_q  <= 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							out_valid_q  <= 1'b1;
							left_q       <= '0;
							prev_q       <= '0;
							have_q       <= 1'b0;
							best_score_q <= SCORE_MAX;
							best_key_q   <= '0;
							best_left_q  <= '0;
							seen_q       <= 1'b0;
						end else begin
							left_q <= left_q + 1'b1;
							prev_q <= value_q;
							have_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item, side terms, accumulators and score
	always_ff @(posedge clk) begin
		if (in_acc) begin
			label_q <= samples.class_label;
			value_q <= samples.sample_value;
			last_q  <= samples.last;
		end
		if (ctl.s1) begin
			l_s1 <= SW'(left_q);
			r_s1 <= SW'(r_wide);
		end
		if (state_q == ST_S2) begin
			lgl_s2 <= lg_q16(32'(l_s1));
			lgr_s2 <= lg_q16(32'(r_s1));
		end
		if (state_q == ST_S3) begin
			posl_s3 <= SIDE_W'(l_s1) * SIDE_W'(lgl_s2);
			posr_s3 <= SIDE_W'(r_s1) * SIDE_W'(lgr_s2);
			ll_s3   <= DEN_W'(l_s1) * DEN_W'(l_s1);
			rr_s3   <= DEN_W'(r_s1) * DEN_W'(r_s1);
			sl_q    <= '0;
			sr_q    <= '0;
			cnt_q   <= '0;
			gl_q    <= '0;
			gr_q    <= '0;
		end
		if (state_q == ST_SH) begin
			sl_q  <= sl_q + ACC_W'(tl_w[0]);
			sr_q  <= sr_q + ACC_W'(tr_w[0]);
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_ED) begin
			d_q <= (pos_c > neg_c) ? pos_c - neg_c : '0;
			x_q <= '0;
			k_q <= '0;
		end
		if (state_q == ST_EM) begin
			if (LN2_Q16[k_q]) begin
				x_q <= x_q + (NUM_W'(d_q) << k_q);
			end
			k_q <= k_q + 1'b1;
		end
		if (state_q == ST_DEW && div_done) begin
			score_q <= div_sat ? SCORE_MAX : div_q[QB_MAX-1:16];
		end
		if (state_q == ST_DLW && div_done) begin
			gl_q <= gsel_c;
		end
		if (state_q == ST_DRW && div_done) begin
			gr_q <= gsel_c;
		end
		if (state_q == ST_CM) begin
			pl_q <= PG_W'(gl_q) * PG_W'(l_s1);
			pr_q <= PG_W'(gr_q) * PG_W'(r_s1);
		end
		if (state_q == ST_DNW && div_done) begin
			score_q <= div_sat ? SCORE_MAX : div_q[SCORE_W-1:0];
		end
		if (upd_go && last_q) begin
			out_found_q <= seen_q;
			out_value_q <= seen_q ? best_key_q : 32'd0;
			out_imp_q   <= seen_q ? best_score_q : '0;
			out_left_q  <= seen_q ? best_left_q : '0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = out_found_q;
	assign result.best_value    = out_value_q;
	assign result.best_impurity = out_imp_q;
	assign result.left_count    = 16'(out_left_q);

	// run state is cleared once the last item of a run is taken
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && last_q) |=> (!have_q && left_q == '0 && !seen_q))
		else $error("run state not cleared after last item");

	// a scored boundary always marks the run as having a split
	a_seen_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BEST) |=> seen_q)
		else $error("split not marked after scoring");

	// the kept best score never rises within a run
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BEST && seen_q) |=> (best_score_q <= $past(best_score_q)))
		else $error("best score increased");

	// the divider is started only when free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule
